// ----- src/bpfa_pkg.sv -----
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BIT_W    = 5;

  localparam logic [WORD_W-1:0] ALL_USED    = 32'hFFFF_FFFF;
  localparam logic [BIT_W-1:0]  BIT_SEL     = 5'd31;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 13'h1FFF;
  localparam logic [CNT_W-1:0]  MANAGED_RST = 13'd4096;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FAILED  = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_MARK_PRIME,
    ST_MARK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic take;
    logic dec;
    logic prime;
    logic scan_step;
    logic mark_step;
    logic resp_load;
    logic clear_wr;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_mark;
    logic scan_found;
    logic scan_end;
    logic mark_end;
    logic clear_end;
    logic out_free;
  } sts_t;

endpackage

// ----- src/bpfa_if.sv -----
// Handshake channels of the allocator: request, response and configuration.
interface bpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::OP_W-1:0]     op;
  logic [bpfa_pkg::FRAME_W-1:0]  first_frame;
  logic [bpfa_pkg::CNT_W-1:0]    frame_count;

  modport source(output valid, output op, output first_frame, output frame_count,
                 input ready);
  modport sink(input valid, input op, input first_frame, input frame_count,
               output ready);
endinterface

interface bpfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::STATUS_W-1:0] status;
  logic [bpfa_pkg::FRAME_W-1:0]  run_start;
  logic [bpfa_pkg::CNT_W-1:0]    free_frames;

  modport source(output valid, output status, output run_start, output free_frames,
                 input ready);
  modport sink(input valid, input status, input run_start, input free_frames,
               output ready);
endinterface

interface bpfa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bpfa_pkg::CNT_W-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/bpfa_ctrl.sv -----
// Sequencer of the allocator: walks each request through decode, scan, mark and reply.
module bpfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bpfa_pkg::sts_t sts_i,
  output bpfa_pkg::cmd_t cmd_o
);

  bpfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        if (sts_i.clear_end) state_d = bpfa_pkg::ST_IDLE;
      end
      bpfa_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = bpfa_pkg::ST_DECODE;
      end
      bpfa_pkg::ST_DECODE: begin
        if (sts_i.go_scan) begin
          state_d = bpfa_pkg::ST_SCAN_PRIME;
        end else if (sts_i.go_mark) begin
          state_d = bpfa_pkg::ST_MARK_PRIME;
        end else begin
          state_d = bpfa_pkg::ST_RESP;
        end
      end
      bpfa_pkg::ST_SCAN_PRIME: state_d = bpfa_pkg::ST_SCAN;
      bpfa_pkg::ST_SCAN: begin
        if (sts_i.scan_found) begin
          state_d = bpfa_pkg::ST_MARK_PRIME;
        end else if (sts_i.scan_end) begin
          state_d = bpfa_pkg::ST_RESP;
        end
      end
      bpfa_pkg::ST_MARK_PRIME: state_d = bpfa_pkg::ST_MARK;
      bpfa_pkg::ST_MARK: begin
        if (sts_i.mark_end) state_d = bpfa_pkg::ST_RESP;
      end
      bpfa_pkg::ST_RESP: begin
        if (sts_i.out_free) state_d = bpfa_pkg::ST_IDLE;
      end
      default: state_d = bpfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      bpfa_pkg::ST_CLEAR: cmd_o.clear_wr = 1'b1;
      bpfa_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
      end
      bpfa_pkg::ST_DECODE:     cmd_o.dec       = 1'b1;
      bpfa_pkg::ST_SCAN_PRIME: cmd_o.prime     = 1'b1;
      bpfa_pkg::ST_SCAN:       cmd_o.scan_step = 1'b1;
      bpfa_pkg::ST_MARK_PRIME: cmd_o.prime     = 1'b1;
      bpfa_pkg::ST_MARK:       cmd_o.mark_step = 1'b1;
      bpfa_pkg::ST_RESP:       cmd_o.resp_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- src/bpfa_dp.sv -----
// Datapath of the allocator: frame bitmap memory, word scan and range marking, counters.
module bpfa_dp #(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpfa_pkg::cmd_t                cmd_i,
  output bpfa_pkg::sts_t                sts_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpfa_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic [bpfa_pkg::OP_W-1:0]     req_op_i,
  input  logic [bpfa_pkg::FRAME_W-1:0]  req_first_frame_i,
  input  logic [bpfa_pkg::CNT_W-1:0]    req_frame_count_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [bpfa_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [bpfa_pkg::FRAME_W-1:0]  rsp_run_start_o,
  output logic [bpfa_pkg::CNT_W-1:0]    rsp_free_frames_o
);

  localparam int unsigned CW    = bpfa_pkg::CNT_W;
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned WW    = bpfa_pkg::WORD_W;
  localparam int unsigned BW    = bpfa_pkg::BIT_W;
  localparam int unsigned FW    = bpfa_pkg::FRAME_W;
  localparam int unsigned WORDS = (NUM_FRAMES + 31) / 32;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [CW-1:0] TOTAL_CAP =
    (NUM_FRAMES > bpfa_pkg::COUNT_MAX) ? bpfa_pkg::COUNT_MAX : CW'(NUM_FRAMES);

  function automatic logic [AW-1:0] word_of(input logic [CW-1:0] pos);
    word_of = AW'(pos >> BW);
  endfunction

  // Bitmap store and its registered read port.
  logic [WW-1:0] mem [WORDS];
  logic [WW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata;

  // Control state.
  logic [CW-1:0] managed_q;
  logic [CW-1:0] free_q;
  logic [AW-1:0] clr_q;
  logic          rsp_valid_q;

  // Request and work registers.
  logic [bpfa_pkg::OP_W-1:0] op_q;
  logic [FW-1:0]             first_q;
  logic [CW-1:0]             count_q;
  logic [AW-1:0]             word_q;
  logic [CW-1:0]             run_q, cand_q;
  logic [CW-1:0]             lo_q, hi_q;
  logic                      set_q;
  bpfa_pkg::status_e         res_status_q;
  logic [CW-1:0]             res_start_q;
  bpfa_pkg::status_e         rsp_status_q;
  logic [FW-1:0]             rsp_start_q;
  logic [CW-1:0]             rsp_free_q;

  // Decode.
  logic [CW-1:0]     total, total_m1, first_ext, avail, n_clip;
  logic              is_alloc, is_range, alloc_ok, start_bad, go_scan, go_mark;
  bpfa_pkg::status_e dec_status;

  // Scan.
  logic [AW-1:0] word_next, last_scan_w;
  logic [CW-1:0] base, found_start;
  logic [WW-1:0] vmask, fmask, acc;
  logic [WW-1:0] pw [BW];
  logic [5:0]    lowfree, highfree, off;
  logic [BW-1:0] hit_pos;
  logic [SW-1:0] sum_run;
  logic          short_count, head_fit, inner_fit, all_free, scan_found;

  // Marking.
  logic [AW-1:0] lo_w, mark_last_w;
  logic [CW-1:0] hi_m1;
  logic [BW-1:0] lo_off, hi_off;
  logic [WW-1:0] mask, flip, new_word;
  logic [5:0]    flips;
  logic [SW-1:0] free_up;
  logic [CW-1:0] free_next;
  logic          out_free;

  assign total     = (managed_q > TOTAL_CAP) ? TOTAL_CAP : managed_q;
  assign total_m1  = total - CW'(1);
  assign first_ext = CW'(first_q);
  assign avail     = total - first_ext;
  assign n_clip    = (count_q > avail) ? avail : count_q;

  assign is_alloc  = (op_q == bpfa_pkg::OP_ALLOC);
  assign is_range  = (op_q == bpfa_pkg::OP_FREE) || (op_q == bpfa_pkg::OP_RESERVE);
  assign alloc_ok  = (count_q != '0) && (count_q <= free_q) && (count_q <= total);
  assign start_bad = (first_ext >= total);
  assign go_scan   = is_alloc && alloc_ok;
  assign go_mark   = is_range && !start_bad && (count_q != '0);

  always_comb begin
    if (is_range) begin
      dec_status = start_bad ? bpfa_pkg::STATUS_IGNORED : bpfa_pkg::STATUS_DONE;
    end else begin
      dec_status = bpfa_pkg::STATUS_FAILED;
    end
  end

  assign word_next   = (word_q == LAST_WORD) ? '0 : word_q + AW'(1);
  assign base        = CW'({word_q, {BW{1'b0}}});
  assign last_scan_w = word_of(total_m1);

  // Frames at or beyond the managed total count as used.
  assign vmask = (word_q == last_scan_w) ?
                 (bpfa_pkg::ALL_USED >> (bpfa_pkg::BIT_SEL - total_m1[BW-1:0])) :
                 bpfa_pkg::ALL_USED;
  assign fmask    = ~rd_q & vmask;
  assign all_free = (fmask == bpfa_pkg::ALL_USED);

  always_comb begin
    lowfree = 6'd32;
    for (int i = WW - 1; i >= 0; i--) begin
      if (!fmask[i]) lowfree = 6'(i);
    end
    highfree = 6'd32;
    for (int i = 0; i < WW; i++) begin
      if (!fmask[i]) highfree = 6'(WW - 1 - i);
    end
  end

  // Window search: for a frame_count below 32, acc[s] is set when that many free bits start at bit s of this word.
  always_comb begin
    pw[0] = fmask;
    for (int b = 1; b < BW; b++) begin
      pw[b] = pw[b-1] & (pw[b-1] >> (1 << (b - 1)));
    end
    acc = bpfa_pkg::ALL_USED;
    off = '0;
    for (int b = 0; b < BW; b++) begin
      if (count_q[b]) begin
        acc = acc & (pw[b] >> off);
        off = off + 6'(1 << b);
      end
    end
    hit_pos = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (acc[i]) hit_pos = BW'(i);
    end
  end

  assign short_count = (count_q[CW-1:BW] == '0);
  assign sum_run     = {1'b0, run_q} + SW'(lowfree);
  assign head_fit    = (sum_run >= {1'b0, count_q});
  assign inner_fit   = short_count && (acc != '0);
  assign scan_found  = head_fit || inner_fit;

  always_comb begin
    if (head_fit) begin
      found_start = (run_q == '0) ? base : cand_q;
    end else begin
      found_start = base + CW'(hit_pos);
    end
  end

  assign lo_w        = word_of(lo_q);
  assign hi_m1       = hi_q - CW'(1);
  assign mark_last_w = word_of(hi_m1);
  assign lo_off      = (word_q == lo_w) ? lo_q[BW-1:0] : '0;
  assign hi_off      = (word_q == mark_last_w) ? hi_m1[BW-1:0] : bpfa_pkg::BIT_SEL;
  assign mask        = (bpfa_pkg::ALL_USED << lo_off) &
                       (bpfa_pkg::ALL_USED >> (bpfa_pkg::BIT_SEL - hi_off));
  assign flip        = set_q ? (mask & ~rd_q) : (mask & rd_q);
  assign new_word    = set_q ? (rd_q | mask) : (rd_q & ~mask);

  always_comb begin
    flips = '0;
    for (int i = 0; i < WW; i++) begin
      flips = flips + 6'(flip[i]);
    end
  end

  // The free count saturates at the top and stops at zero.
  assign free_up = {1'b0, free_q} + SW'(flips);
  always_comb begin
    if (!set_q) begin
      free_next = (free_up > {1'b0, bpfa_pkg::COUNT_MAX}) ? bpfa_pkg::COUNT_MAX :
                  free_up[CW-1:0];
    end else if (CW'(flips) > free_q) begin
      free_next = '0;
    end else begin
      free_next = free_q - CW'(flips);
    end
  end

  assign mem_we    = cmd_i.clear_wr || cmd_i.mark_step;
  assign mem_waddr = cmd_i.clear_wr ? clr_q : word_q;
  assign mem_wdata = cmd_i.clear_wr ? bpfa_pkg::ALL_USED : new_word;
  assign mem_raddr = cmd_i.prime ? word_q : word_next;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      managed_q   <= bpfa_pkg::MANAGED_RST;
      free_q      <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) managed_q <= cfg_data_i;
      if (cmd_i.clear_wr) clr_q <= (clr_q == LAST_WORD) ? '0 : clr_q + AW'(1);
      if (cmd_i.mark_step) free_q <= free_next;
      if (cmd_i.resp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= req_op_i;
      first_q <= req_first_frame_i;
      count_q <= req_frame_count_i;
    end
    if (cmd_i.dec) begin
      word_q       <= go_scan ? '0 : word_of(first_ext);
      run_q        <= '0;
      cand_q       <= '0;
      lo_q         <= first_ext;
      hi_q         <= first_ext + n_clip;
      set_q        <= (op_q != bpfa_pkg::OP_FREE);
      res_status_q <= dec_status;
      res_start_q  <= is_alloc ? '0 : first_ext;
    end
    if (cmd_i.scan_step) begin
      if (scan_found) begin
        lo_q         <= found_start;
        hi_q         <= found_start + count_q;
        word_q       <= word_of(found_start);
        res_status_q <= bpfa_pkg::STATUS_DONE;
        res_start_q  <= found_start;
      end else begin
        word_q <= word_next;
        if (all_free) begin
          run_q  <= run_q + CW'(WW);
          cand_q <= (run_q == '0) ? base : cand_q;
        end else begin
          // Only the free bits at the top of the word can carry into the next one.
          run_q  <= CW'(highfree);
          cand_q <= base + CW'(WW) - CW'(highfree);
        end
      end
    end
    if (cmd_i.mark_step) word_q <= word_next;
    if (cmd_i.resp_load) begin
      rsp_status_q <= res_status_q;
      rsp_start_q  <= res_start_q[FW-1:0];
      rsp_free_q   <= free_q;
    end
  end

  assign out_free = !rsp_valid_q || rsp_ready_i;

  assign sts_o.go_scan    = go_scan;
  assign sts_o.go_mark    = go_mark;
  assign sts_o.scan_found = scan_found;
  assign sts_o.scan_end   = (word_q == last_scan_w);
  assign sts_o.mark_end   = (word_q == mark_last_w);
  assign sts_o.clear_end  = (clr_q == LAST_WORD);
  assign sts_o.out_free   = out_free;

  assign cfg_ready_o       = 1'b1;
  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_run_start_o   = rsp_start_q;
  assign rsp_free_frames_o = rsp_free_q;

endmodule

// ----- src/bitmap_page_frame_allocator_unit.sv -----
// Top level of the bitmap page frame allocator: sequencer, datapath and checks.
//
//   channel  dir  words carried                          accepted when
//   req_i    in   op, first_frame, frame_count           valid && ready
//   rsp_o    out  status, run_start, free_frames         valid && ready
//   cfg_i    in   data (managed_frames)                  valid && ready, always ready
//
// One request is in work at a time. Allocate scans the 32-bit bitmap words for a free run,
// then marks the words the run covers; free and reserve only mark the words of their range;
// rejected requests go straight to the reply. The single read port and single write
// port of the bitmap set one word per cycle in both scan and marking.
// After reset a clearing pass fills all (NUM_FRAMES+31)/32 words with ones before the first
// request is taken. A finished word waits in the output register while the next request
// is accepted; the block stalls only when it must reply and that register is still full.
module bitmap_page_frame_allocator_unit #(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpfa_req_if.sink   req_i,
  bpfa_rsp_if.source rsp_o,
  bpfa_cfg_if.sink   cfg_i
);

  localparam logic [bpfa_pkg::CNT_W-1:0] FREE_CAP =
    (NUM_FRAMES > bpfa_pkg::COUNT_MAX) ? bpfa_pkg::COUNT_MAX : bpfa_pkg::CNT_W'(NUM_FRAMES);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpfa_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_ready_o       (cfg_i.ready),
    .cfg_data_i        (cfg_i.data),
    .req_op_i          (req_i.op),
    .req_first_frame_i (req_i.first_frame),
    .req_frame_count_i (req_i.frame_count),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_run_start_o   (rsp_o.run_start),
    .rsp_free_frames_o (rsp_o.free_frames)
  );

  // The sequencer issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A second request is never taken right behind the first.
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in work");

  // The reported free frame count never exceeds the bitmap size.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.free_frames <= FREE_CAP))
    else $error("free frame count above the bitmap size");

  // A found run is always marked next.
  a_found_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_step && sts.scan_found) |=> cmd.prime)
    else $error("found run not followed by marking");

endmodule

// ----- tb/sv/bpfa_frame_checker.sv -----
// Checker for the page frame allocator: frame map predictor and response scoreboard.
`timescale 1ns / 100ps

module bpfa_frame_checker
  import bpfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpfa_req_if         req_i,
  bpfa_rsp_if         rsp_i,
  bpfa_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned granted_o
);

  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    status_e              status;
    logic [FRAME_W-1:0]   run_start;
    logic [CNT_W-1:0]     free_frames;
  } frame_reply_t;

  // One bit per frame, set when the frame is in use.
  bit [NUM_FRAMES-1:0] frame_used;
  int unsigned         free_total;
  int unsigned         managed_frames;
  int unsigned         fails  = 0;
  int unsigned         grants = 0;
  frame_reply_t        expected_replies[$];

  task automatic report_mismatch(string msg);
    if (fails < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void claim_frame(int unsigned idx);
    if (!frame_used[idx]) begin
      frame_used[idx] = 1'b1;
      if (free_total > 0) free_total--;
    end
  endfunction

  function automatic void release_frame(int unsigned idx);
    if (frame_used[idx]) begin
      frame_used[idx] = 1'b0;
      if (free_total < COUNT_MAX) free_total++;
    end
  endfunction

  // Applies one request to the local frame map and returns the reply it should produce.
  function automatic frame_reply_t predict_frame_op(logic [OP_W-1:0] op,
                                                    logic [FRAME_W-1:0] first,
                                                    logic [CNT_W-1:0] count);
    frame_reply_t r;
    int unsigned  total;
    int unsigned  span;
    int unsigned  run;
    int unsigned  start;
    bit           hit;
    total = (managed_frames > NUM_FRAMES) ? NUM_FRAMES : managed_frames;
    r.status      = STATUS_DONE;
    r.run_start   = first;
    case (op)
      OP_ALLOC: begin
        r.status    = STATUS_FAILED;
        r.run_start = '0;
        if (count != 0 && count <= free_total && count <= total) begin
          run   = 0;
          start = 0;
          hit   = 1'b0;
          for (int unsigned i = 0; i < total && !hit; i++) begin
            if (!frame_used[i]) begin
              if (run == 0) start = i;
              run++;
              if (run == count) hit = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (hit) begin
            for (int unsigned j = 0; j < count; j++) claim_frame(start + j);
            r.status    = STATUS_DONE;
            r.run_start = start[FRAME_W-1:0];
            grants++;
          end
        end
      end
      OP_FREE, OP_RESERVE: begin
        if (first >= total) begin
          r.status = STATUS_IGNORED;
        end else begin
          // The range is clipped at the end of the managed frames.
          span = count;
          if (span > total - first) span = total - first;
          for (int unsigned i = 0; i < span; i++) begin
            if (op == OP_FREE) release_frame(first + i);
            else claim_frame(first + i);
          end
        end
      end
      default: r.status = STATUS_FAILED;
    endcase
    r.free_frames = free_total[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    frame_reply_t want;
    if (!rst_ni) begin
      expected_replies.delete();
      frame_used     = '1;
      free_total     = 0;
      managed_frames = MANAGED_RST;
      pending_o    <= 0;
      fail_count_o <= 0;
      granted_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) managed_frames = cfg_i.data;
      // A response can never belong to a request accepted at the same edge.
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("response word with nothing pending (status %0d)",
                                    rsp_i.status));
        end else begin
          want = expected_replies.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      rsp_i.status, want.status));
          if (rsp_i.run_start !== want.run_start)
            report_mismatch($sformatf("run_start got %0d expected %0d",
                                      rsp_i.run_start, want.run_start));
          if (rsp_i.free_frames !== want.free_frames)
            report_mismatch($sformatf("free_frames got %0d expected %0d",
                                      rsp_i.free_frames, want.free_frames));
        end
      end
      if (req_i.valid && req_i.ready)
        expected_replies.push_back(predict_frame_op(req_i.op, req_i.first_frame,
                                                    req_i.frame_count));
      pending_o    <= expected_replies.size();
      fail_count_o <= fails;
      granted_o    <= grants;
    end
  end

endmodule

// ----- tb/sv/tb_bitmap_page_frame_allocator_unit.sv -----
// Testbench top for the page frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_bitmap_page_frame_allocator_unit;
  import bpfa_pkg::*;

  localparam int unsigned NUM_FRAMES     = 4096;
  localparam int unsigned MAX_GAP        = 19;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 60;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned granted;
  int unsigned sent_items   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned managed_now  = MANAGED_RST;
  int unsigned quiet_cycles = 0;
  bit          burst_mode   = 1'b0;

  bpfa_req_if req_if ();
  bpfa_rsp_if rsp_if ();
  bpfa_cfg_if cfg_if ();

  bitmap_page_frame_allocator_unit #(.NUM_FRAMES(NUM_FRAMES)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  bpfa_frame_checker #(.NUM_FRAMES(NUM_FRAMES)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .granted_o    (granted)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Hands one request word to the block and returns at the edge it is taken.
  task automatic send_request(logic [OP_W-1:0] op, logic [FRAME_W-1:0] first,
                              logic [CNT_W-1:0] count);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.first_frame <= first;
    req_if.frame_count <= count;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sent_items++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_managed(logic [CNT_W-1:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    managed_now = value;
    cfg_writes++;
  endtask

  // Response side: stalls a random number of cycles before taking each word.
  initial begin : responder
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0]   phase_values [RANDOM_PHASES];
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] first;
    logic [CNT_W-1:0]   count;
    int unsigned        total;
    int unsigned        pick;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_ALLOC;
    req_if.first_frame <= '0;
    req_if.frame_count <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Every frame starts out used, so the first allocation is refused.
    send_request(OP_ALLOC,   12'd0,    13'd1);
    send_request(OP_FREE,    12'd0,    13'd4096);
    send_request(OP_FREE,    12'd0,    13'd4096);
    send_request(OP_ALLOC,   12'd0,    13'd0);
    send_request(OP_ALLOC,   12'd0,    13'd4097);
    send_request(OP_ALLOC,   12'd4095, 13'd4096);
    send_request(OP_FREE,    12'd4095, 13'd8191);
    send_request(OP_RESERVE, 12'd4095, 13'd1);
    send_request(OP_FREE,    12'd100,  13'd50);
    send_request(OP_FREE,    12'd10,   13'd3);
    // The three-frame hole at 10 is too short, so this lands at 100.
    send_request(OP_ALLOC,   12'd0,    13'd4);
    send_request(OP_ALLOC,   12'd0,    13'd3);
    send_request(OP_FREE,    12'd0,    13'd0);
    send_request(OP_UNUSED,  12'd4095, 13'd8191);
    send_request(OP_RESERVE, 12'd120,  13'd10);
    send_request(OP_ALLOC,   12'd0,    13'd47);
    // Enough frames are free in total, but no hole is thirty frames long.
    send_request(OP_ALLOC,   12'd0,    13'd30);
    set_managed(13'd0);
    send_request(OP_FREE,    12'd0,    13'd1);
    send_request(OP_ALLOC,   12'd0,    13'd1);
    set_managed(13'd8191);
    send_request(OP_FREE,    12'd4000, 13'd200);
    set_managed(13'd40);
    send_request(OP_FREE,    12'd30,   13'd100);
    send_request(OP_RESERVE, 12'd40,   13'd1);
    send_request(OP_ALLOC,   12'd0,    13'd41);
    send_request(OP_ALLOC,   12'd0,    13'd20);

    phase_values = '{13'd4096, 13'd1, 13'd8191, 13'd4095,
                     CNT_W'($urandom_range(2, 200)), CNT_W'($urandom),
                     13'd64, CNT_W'($urandom_range(500, 4096))};
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      set_managed(phase_values[p]);
      burst_mode = (p % 3 == 2);
      total = (managed_now > NUM_FRAMES) ? NUM_FRAMES : managed_now;
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_ALLOC;
        else if (pick < 75) op = OP_FREE;
        else if (pick < 95) op = OP_RESERVE;
        else                op = OP_UNUSED;
        if (total > 0 && $urandom_range(0, 9) < 8)
          first = FRAME_W'($urandom_range(0, total - 1));
        else
          first = FRAME_W'($urandom);
        // Mostly short runs so that the map fragments, now and then a huge one.
        pick = $urandom_range(0, 19);
        if (pick == 0)       count = '0;
        else if (pick < 14)  count = CNT_W'($urandom_range(1, 16));
        else if (pick < 18)  count = CNT_W'($urandom_range(1, (total > 0) ? total : 1));
        else                 count = CNT_W'($urandom);
        send_request(op, first, count);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests across %0d frame-limit settings, from 0 to 8191.",
             sent_items, cfg_writes);
    $display("%0d allocations were granted; the rest were refused, ignored or ranges.",
             granted);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
